FILE: design/vad_pkg.sv
// vad_pkg: shared types, widths and codes of the voice activity detector
// no dependencies; imported by every design module

package vad_pkg;

  localparam int MAX_BUFFER_SAMPLES = 4096;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 24;
  localparam int THR_W    = 24;
  localparam int RUN_W    = 8;
  localparam int WEIGHT_W = 17;
  localparam int FRAC_W   = 16;

  localparam int CNT_W    = $clog2(MAX_BUFFER_SAMPLES + 1);
  localparam int SQ_W     = 2 * SAMPLE_W - 1;
  localparam int SUM_W    = SQ_W + $clog2(MAX_BUFFER_SAMPLES);
  localparam int RAD_W    = 2 * LEVEL_W;
  localparam int WORK_W   = (SUM_W + FRAC_W > RAD_W) ? SUM_W + FRAC_W : RAD_W;
  localparam int ALIGN_SH = WORK_W - RAD_W;
  localparam int ITER_W   = $clog2(WORK_W);
  localparam int REM_W    = LEVEL_W + 2;
  localparam int OPD_W    = REM_W + 2;
  localparam int PROD_W   = LEVEL_W + WEIGHT_W;
  localparam int ACC_W    = PROD_W + 1;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_W);

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_HOLD   = 2'd1,
    REG_SILENT = 2'd2,
    REG_WEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]    start_threshold;
    logic [THR_W-1:0]    hold_threshold;
    logic [RUN_W-1:0]    silent_buffers_needed;
    logic [WEIGHT_W-1:0] new_weight;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] smoothed_level;
    logic               speaking;
    logic               speaking_changed;
    logic               buffer_overflow;
  } level_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_LAUNCH,
    ST_ROOT,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_SUM,
    ST_COMMIT
  } seq_state_t;

  typedef enum logic [2:0] {
    DS_IDLE,
    DS_DIV,
    DS_ALIGN,
    DS_SQRT,
    DS_DONE
  } ds_state_t;

endpackage

FILE: design/vad_regs.sv
// vad_regs: configuration register file behind the apb-style port
// depends on vad_pkg

module vad_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vad_pkg::ADDR_W-1:0] paddr,
  input  logic [vad_pkg::DATA_W-1:0] pwdata,
  output logic [vad_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output vad_pkg::cfg_t              cfg
);
  import vad_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_threshold       <= THR_W'(150995);
      cfg.hold_threshold        <= THR_W'(83886);
      cfg.silent_buffers_needed <= RUN_W'(8);
      cfg.new_weight            <= WEIGHT_W'(19661);
    end else if (wr_en) begin
      case (idx)
        REG_START:  cfg.start_threshold       <= pwdata[THR_W-1:0];
        REG_HOLD:   cfg.hold_threshold        <= pwdata[THR_W-1:0];
        REG_SILENT: cfg.silent_buffers_needed <= pwdata[RUN_W-1:0];
        REG_WEIGHT: cfg.new_weight            <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START:  prdata = DATA_W'(cfg.start_threshold);
      REG_HOLD:   prdata = DATA_W'(cfg.hold_threshold);
      REG_SILENT: prdata = DATA_W'(cfg.silent_buffers_needed);
      REG_WEIGHT: prdata = DATA_W'(cfg.new_weight);
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: design/vad_mul.sv
// vad_mul: shared unsigned multiplier with a registered product
// depends on vad_pkg; used for sample squares and the average update

module vad_mul (
  input  logic                         clk,
  input  logic [vad_pkg::LEVEL_W-1:0]  a,
  input  logic [vad_pkg::WEIGHT_W-1:0] b,
  output logic [vad_pkg::PROD_W-1:0]   p
);
  import vad_pkg::*;

  logic [PROD_W-1:0] p_next;

  assign p_next = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    p <= p_next;
  end

endmodule

FILE: design/vad_divsqrt.sv
// vad_divsqrt: one shift and subtract unit, first a restoring division of
// sum * 2^16 by count, then a digit-by-digit square root of the quotient
// depends on vad_pkg

module vad_divsqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vad_pkg::SUM_W-1:0]  dividend,
  input  logic [vad_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [vad_pkg::LEVEL_W-1:0] root
);
  import vad_pkg::*;

  ds_state_t          state, state_next;
  logic [WORK_W-1:0]  work;
  logic [REM_W-1:0]   rem;
  logic [ITER_W-1:0]  iter;
  logic [CNT_W-1:0]   dvs;
  logic [OPD_W-1:0]   opa, opb;
  logic [OPD_W:0]     diff;
  logic               ge;

  always_comb begin
    if (state == DS_SQRT) begin
      opa = {rem, work[WORK_W-1 -: 2]};
      opb = OPD_W'({root, 2'b01});
    end else begin
      opa = {1'b0, rem, work[WORK_W-1]};
      opb = OPD_W'(dvs);
    end
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = !diff[OPD_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      DS_IDLE: begin
        if (start) begin
          state_next = (divisor == '0) ? DS_DONE : DS_DIV;
        end
      end
      DS_DIV: begin
        if (iter == '0) begin
          state_next = DS_ALIGN;
        end
      end
      DS_ALIGN: state_next = DS_SQRT;
      DS_SQRT: begin
        if (iter == '0) begin
          state_next = DS_DONE;
        end
      end
      DS_DONE: begin
        done       = 1'b1;
        state_next = DS_IDLE;
      end
      default: state_next = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      DS_IDLE: begin
        if (start) begin
          work <= WORK_W'({dividend, {FRAC_W{1'b0}}});
          dvs  <= divisor;
          rem  <= '0;
          root <= '0;
          iter <= ITER_W'(WORK_W - 1);
        end
      end
      DS_DIV: begin
        work <= {work[WORK_W-2:0], ge};
        rem  <= ge ? diff[REM_W-1:0] : opa[REM_W-1:0];
        iter <= iter - 1'b1;
      end
      DS_ALIGN: begin
        work <= work << ALIGN_SH;
        rem  <= '0;
        root <= '0;
        iter <= ITER_W'(LEVEL_W - 1);
      end
      DS_SQRT: begin
        work <= work << 2;
        rem  <= ge ? diff[REM_W-1:0] : opa[REM_W-1:0];
        root <= {root[LEVEL_W-2:0], ge};
        iter <= iter - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/voice_activity_detector_unit.sv
// voice_activity_detector_unit: top level, sample accumulation, sequencer,
// average update, hysteresis and result register
// depends on vad_pkg, vad_regs, vad_mul, vad_divsqrt
//
//  channel   direction  handshake                      payload
//  sample    in         sample_valid / sample_ready    sample_item_t
//  level     out        level_valid / level_ready      level_item_t
//  config    in         psel penable pwrite / pready   paddr pwdata, prdata
//
// a sample that is not last passes accept, square and accumulate
// a dropped sample skips the square and accumulate steps
// a last sample then goes through the launch, one division step per dividend
// bit (59) and one root step per level bit (24) in the shared subtract unit
// rst clears the control state, counters and average and loads the register defaults
// a result waits in the output register; the next last item stalls only if
// the previous result has not been taken by then

module voice_activity_detector_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  vad_pkg::sample_item_t      sample_item,
  output logic                       level_valid,
  input  logic                       level_ready,
  output vad_pkg::level_item_t       level_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vad_pkg::ADDR_W-1:0] paddr,
  input  logic [vad_pkg::DATA_W-1:0] pwdata,
  output logic [vad_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import vad_pkg::*;

  cfg_t               cfg;
  seq_state_t         state, state_next;

  logic [SAMPLE_W-1:0] samp_mag;
  logic                last_q;
  logic [SUM_W-1:0]    square_sum;
  logic [CNT_W-1:0]    sample_count;
  logic                dropped_flag;
  logic [LEVEL_W-1:0]  average_level;
  logic                speech_flag;
  logic [RUN_W-1:0]    silent_run_count;
  logic [PROD_W-1:0]   acc;
  logic [LEVEL_W-1:0]  avg_new;

  logic                accept;
  logic                room;
  logic                commit;
  logic                ds_start;
  logic                ds_done;
  logic [LEVEL_W-1:0]  level;
  logic [LEVEL_W-1:0]  mul_a;
  logic [WEIGHT_W-1:0] mul_b;
  logic [PROD_W-1:0]   prod;
  logic [WEIGHT_W-1:0] w;
  logic [WEIGHT_W-1:0] wc;
  logic [ACC_W-1:0]    total;
  logic [SAMPLE_W-1:0] mag_in;

  logic                speech_next;
  logic [RUN_W-1:0]    run_next;
  logic [RUN_W-1:0]    run_inc;

  vad_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vad_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  vad_divsqrt u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (ds_start),
    .dividend (square_sum),
    .divisor  (sample_count),
    .done     (ds_done),
    .root     (level)
  );

  assign w      = (cfg.new_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.new_weight;
  assign wc     = WEIGHT_ONE - w;
  assign total  = ACC_W'(acc) + ACC_W'(prod);
  assign accept = sample_valid && sample_ready;
  assign room   = sample_count < CNT_W'(MAX_BUFFER_SAMPLES);
  assign mag_in = sample_item.sample[SAMPLE_W-1] ?
                  SAMPLE_W'(~sample_item.sample + 1'b1) : SAMPLE_W'(sample_item.sample);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    ds_start     = 1'b0;
    commit       = 1'b0;
    mul_a        = average_level;
    mul_b        = wc;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          if (room) begin
            state_next = ST_SQUARE;
          end else if (sample_item.last) begin
            state_next = ST_LAUNCH;
          end
        end
      end
      ST_SQUARE: begin
        mul_a      = LEVEL_W'(samp_mag);
        mul_b      = WEIGHT_W'(samp_mag);
        state_next = ST_ACCUM;
      end
      ST_ACCUM:  state_next = last_q ? ST_LAUNCH : ST_IDLE;
      ST_LAUNCH: begin
        ds_start   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (ds_done) begin
          state_next = ST_MUL_OLD;
        end
      end
      ST_MUL_OLD: state_next = ST_MUL_NEW;
      ST_MUL_NEW: begin
        mul_a      = level;
        mul_b      = w;
        state_next = ST_SUM;
      end
      ST_SUM: state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (!level_valid || level_ready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // hysteresis
  always_comb begin
    run_inc     = (silent_run_count == {RUN_W{1'b1}}) ? silent_run_count :
                  silent_run_count + 1'b1;
    speech_next = speech_flag;
    run_next    = silent_run_count;
    if (speech_flag) begin
      if (avg_new < cfg.hold_threshold) begin
        run_next = run_inc;
        if (run_inc >= cfg.silent_buffers_needed) begin
          speech_next = 1'b0;
        end
      end else begin
        run_next = '0;
      end
    end else if (avg_new > cfg.start_threshold) begin
      run_next    = '0;
      speech_next = 1'b1;
    end
  end

  // buffer state and average
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum       <= '0;
      sample_count     <= '0;
      dropped_flag     <= 1'b0;
      average_level    <= '0;
      speech_flag      <= 1'b0;
      silent_run_count <= '0;
    end else begin
      if (accept) begin
        if (room) begin
          sample_count <= sample_count + 1'b1;
        end else begin
          dropped_flag <= 1'b1;
        end
      end
      if (state == ST_ACCUM) begin
        square_sum <= square_sum + SUM_W'(prod);
      end
      if (commit) begin
        average_level    <= avg_new;
        speech_flag      <= speech_next;
        silent_run_count <= run_next;
        square_sum       <= '0;
        sample_count     <= '0;
        dropped_flag     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      samp_mag <= mag_in;
      last_q   <= sample_item.last;
    end
    if (state == ST_MUL_NEW) begin
      acc <= prod;
    end
    if (state == ST_SUM) begin
      avg_new <= total[FRAC_W +: LEVEL_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      level_valid <= 1'b0;
    end else if (commit) begin
      level_valid <= 1'b1;
    end else if (level_ready) begin
      level_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      level_item.smoothed_level   <= avg_new;
      level_item.speaking         <= speech_next;
      level_item.speaking_changed <= speech_next != speech_flag;
      level_item.buffer_overflow  <= dropped_flag;
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for voice_activity_detector_unit
// holds its own level predictor and drives samples, result back-pressure and the apb port
// depends on vad_pkg and voice_activity_detector_unit

module testbench;
  import vad_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 120;
  localparam int NPHASE        = 7;
  localparam int PHASE_ITEMS   = 180;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    int                         len;
    int                         bufs;
    bit                         closed;
    bit                         typed;
    level_item_t                want;
  } drill_t;

  logic clk;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  sample_item_t sample_item = '0;
  logic level_valid;
  logic level_ready = 1'b0;
  level_item_t level_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  level_item_t level_expected_q[$];
  level_item_t level_want;
  int mismatch_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  cfg_t cfg_shadow = '{start_threshold: 24'd150995, hold_threshold: 24'd83886,
                       silent_buffers_needed: 8'd8, new_weight: 17'd19661};
  logic [63:0]        energy_sum = '0;
  int                 buf_count = 0;
  logic               buf_dropped = 1'b0;
  logic [LEVEL_W-1:0] avg_level = '0;
  logic               speech_now = 1'b0;
  logic [RUN_W-1:0]   silent_run = '0;

  drill_t drills [12] = '{
    '{16'sh0000, 1, 1, 1, 1, '{24'd0, 1'b0, 1'b0, 1'b0}},
    '{16'sh8000, 1, 1, 1, 1, '{24'd2516608, 1'b1, 1'b1, 1'b0}},
    '{16'sh7fff, 1, 1, 1, 0, '0},
    '{16'sh5555, 1, 1, 0, 0, '0},
    '{16'shaaaa, 1, 1, 0, 0, '0},
    '{16'sh0001, 1, 1, 1, 0, '0},
    '{16'sh0000, 4, 30, 1, 0, '0},
    '{16'sh2ee0, 8, 4, 1, 0, '0},
    '{16'shffff, 5, 3, 1, 0, '0},
    '{16'sh8000, MAX_BUFFER_SAMPLES, 1, 1, 0, '0},
    '{16'sh8000, MAX_BUFFER_SAMPLES + 1, 1, 1, 0, '0},
    '{16'sh0000, 1, 1, 1, 0, '0}
  };

  voice_activity_detector_unit uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .level_valid  (level_valid),
    .level_ready  (level_ready),
    .level_item   (level_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] radicand);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic bit predict_level(input logic signed [SAMPLE_W-1:0] value,
                                       input logic is_last, output level_item_t res);
    logic [63:0] level;
    logic [63:0] weight;
    logic [63:0] mixed;
    logic        was_speaking;
    res = '0;
    was_speaking = speech_now;
    if (buf_count < MAX_BUFFER_SAMPLES) begin
      energy_sum += 64'(longint'(value) * longint'(value));
      buf_count++;
    end else begin
      buf_dropped = 1'b1;
    end
    if (!is_last) return 1'b0;
    level = (buf_count != 0) ? root_floor((energy_sum << FRAC_W) / buf_count) : 64'd0;
    weight = (cfg_shadow.new_weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE)
                                                  : 64'(cfg_shadow.new_weight);
    mixed = (64'(avg_level) * (64'(WEIGHT_ONE) - weight) + level * weight) >> FRAC_W;
    avg_level = mixed[LEVEL_W-1:0];
    if (speech_now) begin
      if (avg_level < cfg_shadow.hold_threshold) begin
        if (silent_run != '1) silent_run++;
        if (silent_run >= cfg_shadow.silent_buffers_needed) speech_now = 1'b0;
      end else begin
        silent_run = '0;
      end
    end else if (avg_level > cfg_shadow.start_threshold) begin
      silent_run = '0;
      speech_now = 1'b1;
    end
    res.smoothed_level   = avg_level;
    res.speaking         = speech_now;
    res.speaking_changed = speech_now != was_speaking;
    res.buffer_overflow  = buf_dropped;
    energy_sum  = '0;
    buf_count   = 0;
    buf_dropped = 1'b0;
    return 1'b1;
  endfunction

  task automatic access_reg(input reg_idx_t idx, input bit do_write,
                            input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] held;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= do_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_START:  held = DATA_W'(cfg_shadow.start_threshold);
      REG_HOLD:   held = DATA_W'(cfg_shadow.hold_threshold);
      REG_SILENT: held = DATA_W'(cfg_shadow.silent_buffers_needed);
      default:    held = DATA_W'(cfg_shadow.new_weight);
    endcase
    if (do_write) begin
      case (idx)
        REG_START:  cfg_shadow.start_threshold       = value[THR_W-1:0];
        REG_HOLD:   cfg_shadow.hold_threshold        = value[THR_W-1:0];
        REG_SILENT: cfg_shadow.silent_buffers_needed = value[RUN_W-1:0];
        default:    cfg_shadow.new_weight            = value[WEIGHT_W-1:0];
      endcase
    end else if (prdata !== held) begin
      $error("prdata of %s expected %0d got %0d", idx.name(), held, prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic is_last,
                             input bit typed, input level_item_t typed_want);
    level_item_t predicted;
    bit          produced;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_item  <= '{sample: value, last: is_last};
    do @(posedge clk); while (!sample_ready);
    produced = predict_level(value, is_last, predicted);
    if (produced) level_expected_q.push_back(typed ? typed_want : predicted);
    @(negedge clk);
  endtask

  task automatic send_buffer(input int len, input bit loud);
    logic signed [SAMPLE_W-1:0] value;
    int                         shift;
    shift = $urandom_range(3, 15);
    for (int n = 0; n < len; n++) begin
      value = SAMPLE_W'($urandom);
      if ($urandom_range(0, 15) == 0) value = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      else if (!loud) value = value >>> shift;
      send_sample(value, n == len - 1, 1'b0, '0);
    end
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (level_expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] start_thr, input logic [DATA_W-1:0] hold_thr,
                            input logic [DATA_W-1:0] silent, input logic [DATA_W-1:0] weight);
    drain();
    access_reg(REG_START, 1'b1, start_thr);
    access_reg(REG_HOLD, 1'b1, hold_thr);
    access_reg(REG_SILENT, 1'b1, silent);
    access_reg(REG_WEIGHT, 1'b1, weight);
    for (int i = 0; i < 4; i++) access_reg(reg_idx_t'(i), 1'b0, '0);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      level_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      level_ready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      level_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && level_valid && level_ready) begin
      if (level_expected_q.size() == 0) begin
        $error("level item with no expectation pending");
        mismatch_count++;
      end else begin
        level_want = level_expected_q.pop_front();
        if (level_item.smoothed_level !== level_want.smoothed_level) begin
          $error("smoothed_level expected %0d got %0d",
                 level_want.smoothed_level, level_item.smoothed_level);
          mismatch_count++;
        end
        if (level_item.speaking !== level_want.speaking) begin
          $error("speaking expected %0d got %0d", level_want.speaking, level_item.speaking);
          mismatch_count++;
        end
        if (level_item.speaking_changed !== level_want.speaking_changed) begin
          $error("speaking_changed expected %0d got %0d",
                 level_want.speaking_changed, level_item.speaking_changed);
          mismatch_count++;
        end
        if (level_item.buffer_overflow !== level_want.buffer_overflow) begin
          $error("buffer_overflow expected %0d got %0d",
                 level_want.buffer_overflow, level_item.buffer_overflow);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("voice_activity_detector_unit verification failed");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          run_left;
    int          len;
    int          pick;
    bit          loud;
    logic [31:0] start_thr;
    logic [31:0] hold_thr;
    logic [31:0] silent;
    logic [31:0] weight;
    run_left = 0;
    loud = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < 4; i++) access_reg(reg_idx_t'(i), 1'b0, '0);

    idle_pct  = 20;
    stall_pct = 20;
    foreach (drills[r]) begin
      for (int b = 0; b < drills[r].bufs; b++) begin
        for (int n = 0; n < drills[r].len; n++) begin
          send_sample(drills[r].value, drills[r].closed && n == drills[r].len - 1,
                      drills[r].typed, drills[r].want);
        end
      end
    end

    for (int p = 0; p < NPHASE; p++) begin
      start_thr = $urandom_range(20000, 3000000);
      hold_thr  = $urandom_range(0, start_thr + start_thr / 2);
      silent    = $urandom_range(1, 12);
      weight    = $urandom_range(1000, 65536);
      case (p)
        0: begin
          start_thr = 0;
          hold_thr  = 0;
          silent    = 1;
          weight    = 65536;
        end
        1: begin
          start_thr = 8388608;
          hold_thr  = 8388608;
          silent    = 255;
          weight    = 0;
        end
        2: begin
          silent = 0;
          weight = 131071;
        end
        default: ;
      endcase
      set_config(start_thr, hold_thr, silent, weight);
      if (p == NPHASE - 1) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 20 * $urandom_range(0, 2);
        stall_pct = 20 * $urandom_range(0, 2);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (run_left == 0) begin
          loud     = $urandom_range(0, 1);
          run_left = $urandom_range(1, 16);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(1, 8);
        else if (pick < 95) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 120);
        send_buffer(len, loud);
        sent += len;
        run_left--;
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("voice_activity_detector_unit verification clean");
    end else begin
      $display("voice_activity_detector_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/vad_pkg.sv
design/vad_regs.sv
design/vad_mul.sv
design/vad_divsqrt.sv
design/voice_activity_detector_unit.sv
tb/testbench.sv
